>>> sv/rpt_pkg.sv
// ----------------------------------------------------------------------------
// region profile table package
// shared widths, codes and the structs that travel along the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package rpt_pkg;

   localparam int SLOTS     = 16;
   localparam int TIME_BITS = 48;

   // fixed field widths of the stream payload
   localparam int KEY_W   = 32;
   localparam int SEL_W   = 4;
   localparam int TS_W    = 48;
   localparam int CALLS_W = 32;
   localparam int TOTAL_W = 64;

   localparam int IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CMP_W    = (IDX_BITS > SEL_W) ? IDX_BITS : SEL_W;

   localparam logic [63:0] MIN_INIT_RAW = 64'd100000000000;
   localparam logic [63:0] TIME_MASK    = (64'd1 << TIME_BITS) - 64'd1;
   localparam logic [TIME_BITS-1:0] MIN_INIT =
      (MIN_INIT_RAW > TIME_MASK) ? TIME_MASK[TIME_BITS-1:0]
                                 : MIN_INIT_RAW[TIME_BITS-1:0];

   typedef enum logic [1:0] {
      OP_BEGIN = 2'd0,
      OP_END   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_UPD
   } state_type;

   // broadcast to every cell
   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [SEL_W-1:0]     idx;
      logic [TIME_BITS-1:0] ts;
      logic                 any_match;
      logic                 look;
      logic                 update;
   } cell_ctl_type;

   // priority scan handed from cell to cell, lowest slot first
   typedef struct packed {
      logic match_seen;
      logic free_seen;
   } scan_type;

   // slot statistics, or-ed along the chain by the one selected cell
   typedef struct packed {
      logic                 any;
      logic [IDX_BITS-1:0]  slot;
      logic [KEY_W-1:0]     key;
      logic [CALLS_W-1:0]   calls;
      logic [TOTAL_W-1:0]   total;
      logic [TIME_BITS-1:0] min_t;
      logic [TIME_BITS-1:0] max_t;
   } stats_type;

endpackage

`default_nettype wire

>>> sv/rpt_cell.sv
// ----------------------------------------------------------------------------
// region profile table cell
// one table slot: key match, scan hand-off and the begin/end update
// ----------------------------------------------------------------------------
`default_nettype none

module rpt_cell
   import rpt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctl_type        ctl,
   input  wire logic [IDX_BITS-1:0] cell_idx,
   input  wire scan_type            scan_in,
   output scan_type                 scan_out,
   input  wire stats_type           stats_in,
   output stats_type                stats_out,
   output logic                     sel
);

   logic                 valid_ff, valid_in;
   logic                 hit_ff, hit_in;
   logic                 free_ff, free_in;
   logic [KEY_W-1:0]     key_ff;
   logic [TIME_BITS-1:0] start_ff;
   logic [CALLS_W-1:0]   calls_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic [TIME_BITS-1:0] min_ff;
   logic [TIME_BITS-1:0] max_ff;

   logic                 match;
   logic                 alloc;
   logic [CALLS_W-1:0]   calls_b, calls_n;
   logic [TOTAL_W-1:0]   total_b, total_n;
   logic [TIME_BITS-1:0] min_b, min_n, max_b, max_n, start_n;
   logic [TIME_BITS-1:0] elapsed;
   logic [TOTAL_W:0]     sum;
   stats_type            mine;

   assign match = valid_ff && (key_ff == ctl.key);

   assign scan_out.match_seen = scan_in.match_seen | match;
   assign scan_out.free_seen  = scan_in.free_seen | ~valid_ff;

   always_comb begin
      hit_in  = hit_ff;
      free_in = free_ff;
      if (ctl.look) begin
         hit_in  = match & ~scan_in.match_seen;
         free_in = ~valid_ff & ~scan_in.free_seen;
      end
   end

   always_comb begin
      unique case (ctl.op)
         OP_BEGIN: sel = hit_ff | (free_ff & ~ctl.any_match);
         OP_END:   sel = hit_ff;
         OP_READ:  sel = valid_ff && (CMP_W'(cell_idx) == CMP_W'(ctl.idx));
         OP_CLEAR: sel = 1'b0;
         default:  sel = 1'b0;
      endcase
   end

   assign alloc = (ctl.op == OP_BEGIN) & free_ff & ~ctl.any_match;

   // fresh slot starts from cleared statistics
   assign calls_b = alloc ? '0 : calls_ff;
   assign total_b = alloc ? '0 : total_ff;
   assign min_b   = alloc ? MIN_INIT : min_ff;
   assign max_b   = alloc ? '0 : max_ff;

   assign elapsed = ctl.ts - start_ff;
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(elapsed);

   always_comb begin
      calls_n = calls_b;
      total_n = total_b;
      min_n   = min_b;
      max_n   = max_b;
      start_n = start_ff;
      unique case (ctl.op)
         OP_BEGIN: begin
            start_n = ctl.ts;
            if (calls_b != '1) begin
               calls_n = calls_b + CALLS_W'(1);
            end
         end
         OP_END: begin
            total_n = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (elapsed > max_ff) begin
               max_n = elapsed;
            end
            if (elapsed < min_ff) begin
               min_n = elapsed;
            end
         end
         OP_READ, OP_CLEAR: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.update) begin
         if (ctl.op == OP_CLEAR) begin
            valid_in = 1'b0;
         end else if (alloc) begin
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && sel) begin
         if (alloc) begin
            key_ff <= ctl.key;
         end
         start_ff <= start_n;
         calls_ff <= calls_n;
         total_ff <= total_n;
         min_ff   <= min_n;
         max_ff   <= max_n;
      end
   end

   always_comb begin
      mine.any   = 1'b1;
      mine.slot  = cell_idx;
      mine.key   = alloc ? ctl.key : key_ff;
      mine.calls = calls_n;
      mine.total = total_n;
      mine.min_t = min_n;
      mine.max_t = max_n;
   end

   assign stats_out = stats_in | (sel ? mine : '0);

endmodule

`default_nettype wire

>>> sv/region_profile_table_unit.sv
// ----------------------------------------------------------------------------
// region profile table unit
// table of profiled regions keyed by region id, built as a chain of slot cells
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents
//  req_     in   tuser: command; tdata: region_key, slot_index, timestamp
//  rsp_     out  tuser: status; tdata: slot_used, key_out, call_count,
//                total_ticks, min_ticks, max_ticks
//
//  every command passes through the accept cycle in idle, a scan cycle where
//  each cell matches its key and the priority hand-off along the chain
//  marks the lowest hit and the lowest free slot, and an update cycle where
//  the selected cell writes back and drives the result chain; the result
//  beat is registered at the end of the update cycle
//  a new beat is taken only in idle, so one command is in flight at a time
//  while the result register holds a beat that is not taken, the update
//  cycle waits; a new command may be accepted while a finished result waits
//  synchronous reset drops every entry and the pending result
//
`default_nettype none

module region_profile_table_unit
   import rpt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [87:0]  req_tdata,  // region_key[31:0], slot_index[35:32],
                                         // timestamp[83:36], zero pad
   input  wire logic [1:0]   req_tuser,  // command

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [231:0]      rsp_tdata,  // slot_used[3:0], key_out[35:4],
                                         // call_count[67:36],
                                         // total_ticks[131:68],
                                         // min_ticks[179:132],
                                         // max_ticks[227:180], zero pad
   output logic [1:0]        rsp_tuser   // status
);

   state_type            state_ff, state_in;

   // captured command beat
   op_type               op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [SEL_W-1:0]     idx_ff;
   logic [TIME_BITS-1:0] ts_ff;
   logic                 any_match_ff, any_match_in;
   logic                 any_free_ff, any_free_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [227:0]         rsp_data_ff;
   status_type           rsp_status_ff;

   logic                 req_fire;
   logic                 out_free;
   logic                 look;
   logic                 update;
   cell_ctl_type         ctl;
   scan_type             scan [SLOTS+1];
   stats_type            stats [SLOTS+1];
   logic [SLOTS-1:0]     cell_sel;

   status_type           status_n;
   logic [SEL_W-1:0]     slot_n;
   logic [KEY_W-1:0]     key_n;
   stats_type            result;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign req_fire = req_tvalid & req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) begin
            state_in = S_LOOK;
         end
         S_LOOK: state_in = S_UPD;
         S_UPD: if (out_free) begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      look       = 1'b0;
      update     = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_LOOK:  look = 1'b1;
         S_UPD:   update = out_free;
         default: req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= op_type'(req_tuser);
         key_ff <= req_tdata[31:0];
         idx_ff <= req_tdata[35:32];
         ts_ff  <= req_tdata[36 +: TIME_BITS];
      end
   end

   // chain end of the scan tells whether any slot hit or is free
   assign any_match_in = look ? scan[SLOTS].match_seen : any_match_ff;
   assign any_free_in  = look ? scan[SLOTS].free_seen  : any_free_ff;

   always_ff @(posedge clock) begin
      any_match_ff <= any_match_in;
      any_free_ff  <= any_free_in;
   end

   always_comb begin
      ctl.op        = op_ff;
      ctl.key       = key_ff;
      ctl.idx       = idx_ff;
      ctl.ts        = ts_ff;
      ctl.any_match = any_match_ff;
      ctl.look      = look;
      ctl.update    = update;
   end

   assign scan[0]  = '0;
   assign stats[0] = '0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      rpt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .cell_idx  (IDX_BITS'(g)),
         .scan_in   (scan[g]),
         .scan_out  (scan[g+1]),
         .stats_in  (stats[g]),
         .stats_out (stats[g+1]),
         .sel       (cell_sel[g])
      );
   end

   assign result = stats[SLOTS];

   // status and failure fields
   always_comb begin
      status_n = ST_OK;
      slot_n   = SEL_W'(result.slot);
      key_n    = result.key;
      unique case (op_ff)
         OP_BEGIN: if (!any_match_ff && !any_free_ff) begin
            status_n = ST_FULL;
            key_n    = key_ff;
         end
         OP_END: if (!any_match_ff) begin
            status_n = ST_NOT_FOUND;
            key_n    = key_ff;
         end
         OP_READ: begin
            slot_n = idx_ff;
            if (!result.any) begin
               status_n = ST_EMPTY;
            end
         end
         OP_CLEAR: status_n = ST_OK;
         default:  status_n = ST_OK;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_status_ff <= status_n;
         rsp_data_ff   <= {TS_W'(result.max_t), TS_W'(result.min_t), result.total,
                           result.calls, key_n, slot_n};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   // never two cells answer one command
   a_one_sel : assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_sel))
      else $error("more than one slot selected");

   // a key seen in the scan selects exactly one cell for begin and end
   a_hit_sel : assert property (@(posedge clock) disable iff (reset)
      (update && any_match_ff && (op_ff == OP_BEGIN || op_ff == OP_END))
         |-> ($countones(cell_sel) == 1))
      else $error("scan hit without a selected slot");

   // an accepted beat always moves on to the scan cycle
   a_accept_look : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_LOOK))
      else $error("accepted beat not scanned");

   // the update cycle always leaves a result behind
   a_update_rsp : assert property (@(posedge clock) disable iff (reset)
      update |=> rsp_tvalid)
      else $error("update without a result beat");

endmodule

`default_nettype wire

>>> tb/sv/tb_region_profile_checker.sv
// ----------------------------------------------------------------------------
// region profile table checker
// watches both stream channels, keeps its own copy of the profile table and
// compares every result beat with the oldest predicted one
// ----------------------------------------------------------------------------

module tb_region_profile_checker
   import rpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [231:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   output int           mismatch_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type           status;
      logic [3:0]           slot;
      logic [KEY_W-1:0]     key;
      logic [CALLS_W-1:0]   calls;
      logic [TOTAL_W-1:0]   total;
      logic [TIME_BITS-1:0] min_t;
      logic [TIME_BITS-1:0] max_t;
   } region_stats_type;

   bit                   slot_valid [SLOTS];
   logic [KEY_W-1:0]     slot_key   [SLOTS];
   logic [TIME_BITS-1:0] slot_start [SLOTS];
   logic [CALLS_W-1:0]   slot_calls [SLOTS];
   logic [TOTAL_W-1:0]   slot_total [SLOTS];
   logic [TIME_BITS-1:0] slot_min   [SLOTS];
   logic [TIME_BITS-1:0] slot_max   [SLOTS];

   region_stats_type expected_stats_q [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic region_stats_type empty_stats(status_type st, logic [3:0] slot,
                                                    logic [KEY_W-1:0] key);
      region_stats_type r;
      r.status = st;
      r.slot   = slot;
      r.key    = key;
      r.calls  = '0;
      r.total  = '0;
      r.min_t  = '0;
      r.max_t  = '0;
      return r;
   endfunction

   function automatic region_stats_type slot_stats(int s);
      region_stats_type r;
      r.status = ST_OK;
      r.slot   = s[3:0];
      r.key    = slot_key[s];
      r.calls  = slot_calls[s];
      r.total  = slot_total[s];
      r.min_t  = slot_min[s];
      r.max_t  = slot_max[s];
      return r;
   endfunction

   // lowest valid slot holding the key, -1 when absent
   function automatic int find_region(logic [KEY_W-1:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   // updates the table for one command and returns the result it produces
   function automatic region_stats_type apply_command(op_type op, logic [KEY_W-1:0] key,
                                                      logic [3:0] idx,
                                                      logic [TIME_BITS-1:0] ts);
      int                   hit;
      logic [TIME_BITS-1:0] elapsed;
      logic [TOTAL_W:0]     sum;
      case (op)
         OP_BEGIN: begin
            hit = find_region(key);
            if (hit < 0) begin
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_valid[i]) hit = i;
               if (hit < 0) return empty_stats(ST_FULL, '0, key);
               slot_valid[hit] = 1'b1;
               slot_key[hit]   = key;
               slot_calls[hit] = '0;
               slot_total[hit] = '0;
               slot_max[hit]   = '0;
               slot_min[hit]   = MIN_INIT;
            end
            slot_start[hit] = ts;
            if (slot_calls[hit] != '1) slot_calls[hit] = slot_calls[hit] + 1'b1;
            return slot_stats(hit);
         end
         OP_END: begin
            hit = find_region(key);
            if (hit < 0) return empty_stats(ST_NOT_FOUND, '0, key);
            // elapsed wraps at the timer width, the total saturates
            elapsed = ts - slot_start[hit];
            sum = {1'b0, slot_total[hit]} + elapsed;
            slot_total[hit] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (elapsed > slot_max[hit]) slot_max[hit] = elapsed;
            if (elapsed < slot_min[hit]) slot_min[hit] = elapsed;
            return slot_stats(hit);
         end
         OP_READ: begin
            if (idx < SLOTS && slot_valid[idx]) return slot_stats(idx);
            return empty_stats(ST_EMPTY, idx, '0);
         end
         default: begin
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            return empty_stats(ST_OK, '0, '0);
         end
      endcase
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%t rsp %s mismatch: expected %h actual %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      region_stats_type want;
      if (reset) begin
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         expected_stats_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_stats_q.push_back(apply_command(op_type'(req_tuser), req_tdata[31:0],
                                                     req_tdata[35:32],
                                                     req_tdata[36 +: TIME_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stats_q.size() == 0) begin
               mismatch_count++;
               $display("%t unexpected rsp beat: expected none actual %h %h",
                        $realtime, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_stats_q.pop_front();
               check_field("status",      want.status, rsp_tuser);
               check_field("slot_used",   want.slot,   rsp_tdata[3:0]);
               check_field("key_out",     want.key,    rsp_tdata[35:4]);
               check_field("call_count",  want.calls,  rsp_tdata[67:36]);
               check_field("total_ticks", want.total,  rsp_tdata[131:68]);
               check_field("min_ticks",   want.min_t,  rsp_tdata[179:132]);
               check_field("max_ticks",   want.max_t,  rsp_tdata[227:180]);
            end
         end
      end
      pending_count <= expected_stats_q.size();
   end

endmodule

>>> tb/sv/tb_region_profile_table_unit.sv
// ----------------------------------------------------------------------------
// region profile table unit testbench
// drives begin, end, read and clear commands under several idle and stall
// mixes, including timer wrap and a full table; the checker does the scoring
// ----------------------------------------------------------------------------

module tb_region_profile_table_unit;
   import rpt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int PHASE_BEATS  = 205;
   localparam int KEY_POOL     = 24;
   localparam int HOLD_CYCLES  = 300;

   logic         clock = 1'b0;
   logic         reset;

   logic         req_tvalid;
   logic         req_tready;
   logic [87:0]  req_tdata;   // region_key[31:0], slot_index[35:32], timestamp[83:36], pad
   logic [1:0]   req_tuser;   // command

   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [231:0] rsp_tdata;   // slot_used[3:0], key_out[35:4], call_count[67:36],
                              // total_ticks[131:68], min_ticks[179:132],
                              // max_ticks[227:180], pad
   logic [1:0]   rsp_tuser;   // status

   int           mismatch_count;
   int           pending_count;
   int           cycle_count = 0;

   // idle mix: sender side is read by the stimulus process itself,
   // receiver side by the ready process
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   logic         hold_off_req = 1'b0;

   logic [KEY_W-1:0]     key_pool [KEY_POOL];
   logic [KEY_W-1:0]     last_begun;
   logic [TIME_BITS-1:0] tick;

   always #5 clock = ~clock;

   region_profile_table_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tb_region_profile_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side ready: random stalls, plus one long hold-off on request
   // so the block backs up and stops taking command beats
   initial begin : ready_driver
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // offer one command beat and hold it until the block takes it;
   // valid stays high into the next beat unless an idle gap is drawn
   task automatic send_beat(op_type op, logic [KEY_W-1:0] key, logic [3:0] idx,
                            logic [TIME_BITS-1:0] ts);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, ts, idx, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // sender goes quiet until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // mostly begin/end pairs on a small key set so the table fills and hits,
   // with reads, rare clears and some stray keys mixed in
   task automatic random_beat();
      int                   pick;
      op_type               op;
      logic [KEY_W-1:0]     key;
      pick = $urandom_range(0, 999);
      if (pick < 400)      op = OP_BEGIN;
      else if (pick < 780) op = OP_END;
      else if (pick < 985) op = OP_READ;
      else                 op = OP_CLEAR;
      if ($urandom_range(0, 99) < 8)
         key = $urandom;
      else if (op == OP_END && $urandom_range(0, 99) < 60)
         key = last_begun;
      else
         key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      // time mostly creeps forward, now and then jumps anywhere
      if ($urandom_range(0, 99) < 5)
         tick = TIME_BITS'({$urandom, $urandom});
      else
         tick = tick + $urandom_range(0, 5000);
      if (op == OP_BEGIN) last_begun = key;
      send_beat(op, key, 4'($urandom_range(0, 15)), tick);
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_BEGIN;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
      last_begun = key_pool[0];
      tick       = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // empty table: reads of both end slots, end of an absent key
      send_beat(OP_READ,  '0, 4'd0,  '0);
      send_beat(OP_READ,  '1, 4'd15, '1);
      send_beat(OP_END,   '0, 4'd0,  48'd10);
      // allocate slot 0 and slot 1 at the timestamp extremes
      send_beat(OP_BEGIN, '0, 4'd0,  '0);
      send_beat(OP_BEGIN, '1, 4'd15, '1);
      send_beat(OP_END,   '0, 4'd0,  48'd5);
      // start near the top of the timer, end just past the wrap
      send_beat(OP_END,   '1, 4'd0,  48'd3);
      // end again with no new begin reuses the old start, longest interval
      send_beat(OP_END,   '0, 4'd0,  '1);
      // second call on an existing key, then a zero-length interval
      send_beat(OP_BEGIN, '0, 4'd0,  48'd100);
      send_beat(OP_END,   '0, 4'd0,  48'd100);
      send_beat(OP_READ,  '0, 4'd0,  '0);
      send_beat(OP_READ,  '0, 4'd2,  '0);
      // fill the rest of the table, then one begin too many
      for (int i = 0; i < SLOTS - 2; i++)
         send_beat(OP_BEGIN, 32'h0000_1000 + i, 4'(i), 48'(i));
      send_beat(OP_BEGIN, 32'hDEAD_BEEF, 4'd0, 48'd7);
      send_beat(OP_CLEAR, '0, 4'd0, '0);
      send_beat(OP_READ,  '0, 4'd1, '0);
      drain_results();

      // --- random phases: no idling, sender idle, receiver stall, both ---
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 71;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 71;
            end
            default: begin
               send_idle_pct = 20;
               stall_pct <= 20;
            end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (ph == 0 && n == 40) hold_off_req <= 1'b1;
            random_beat();
         end
         drain_results();
      end

      // let any stray beat show up before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
